// ===== rtl/dtree_pkg.sv =====
// shared types and constants for the decision tree evaluator
package dtree_pkg;

  // function codes on the input channel
  localparam logic [1:0] FUNC_NODE = 2'd0;
  localparam logic [1:0] FUNC_FEAT = 2'd1;
  localparam logic [1:0] FUNC_EVAL = 2'd2;

  // reset value of the feature count register
  localparam logic [6:0] FCOUNT_RESET = 7'd64;

  // command queue depth between front and back
  localparam int QDEPTH = 2;
  localparam int QAW    = 1;

  // classified command kinds
  typedef enum logic [1:0] {
    OP_NODE,
    OP_FEAT,
    OP_EVAL
  } op_t;

  // result status codes
  typedef enum logic [1:0] {
    ST_OK   = 2'd0,
    ST_DIM  = 2'd1,
    ST_WALK = 2'd2
  } status_t;

  // back end sequencer states
  typedef enum logic [1:0] {
    B_IDLE,
    B_NODE,
    B_FEAT,
    B_DONE
  } bstate_t;

  // one classified command; a feature write uses index and value
  typedef struct packed {
    op_t                op;
    logic [7:0]         index;
    logic               leaf;
    logic [5:0]         dim;
    logic signed [31:0] cut;
    logic [7:0]         child_below;
    logic [7:0]         child_above;
    logic signed [31:0] value;
  } cmd_t;

  // one node table entry
  typedef struct packed {
    logic               leaf;
    logic [5:0]         dim;
    logic signed [31:0] cut;
    logic [7:0]         child_below;
    logic [7:0]         child_above;
    logic signed [31:0] value;
  } node_t;

endpackage

// ===== rtl/decision_tree_evaluator.sv =====
// decision tree evaluator top level: front end, command queue and back end
//
// Input channel (in_valid/in_ready) takes three kinds of item chosen by func:
// node write, feature write and evaluate. Writes give no result; an evaluate
// item gives one result (score, status) on the output channel
// (out_valid/out_ready). Function code 3 and writes to indexes beyond the
// tables are dropped at the front end.
// The single register feature_count is written by cfg_we/cfg_wdata. The user
// must write it only while the block is idle; the block itself does not enforce
// this. Reset sets it to 64. A write item is done in the idle state. An
// evaluate item reads the root node; each inner node passed then costs one
// feature store read and one node table read of its child, each registered.
// The walk ends in the done state, which loads the output register.
// A two-entry queue sits between front and back end, so the input keeps taking
// items while the back end walks, until it fills. A stalled receiver holds only
// the output register; the back end finishes the next walk and then waits.
// Reset (rst, synchronous) empties the queue and the output register; the node
// and feature tables are not cleared and must be written before use.
module decision_tree_evaluator #(
  parameter int NODES    = 256,
  parameter int FEATURES = 64
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               cfg_we,
  input  logic [6:0]         cfg_wdata,
  input  logic               in_valid,
  output logic               in_ready,
  input  logic [1:0]         func,
  input  logic [7:0]         node_index,
  input  logic               leaf,
  input  logic [5:0]         node_dim,
  input  logic signed [31:0] cut,
  input  logic [7:0]         child_below,
  input  logic [7:0]         child_above,
  input  logic signed [31:0] leaf_score,
  input  logic [5:0]         feature_index,
  input  logic signed [31:0] feature_value,
  output logic               out_valid,
  input  logic               out_ready,
  output logic signed [31:0] score,
  output logic [1:0]         status
);
  import dtree_pkg::*;

  logic fq_valid;
  logic fq_ready;
  cmd_t fq_cmd;
  logic qb_valid;
  logic qb_ready;
  cmd_t qb_cmd;

  // classify incoming items
  dtree_front #(
    .NODES    (NODES),
    .FEATURES (FEATURES)
  ) u_front (
    .clk           (clk),
    .rst           (rst),
    .in_valid      (in_valid),
    .in_ready      (in_ready),
    .func          (func),
    .node_index    (node_index),
    .leaf          (leaf),
    .node_dim      (node_dim),
    .cut           (cut),
    .child_below   (child_below),
    .child_above   (child_above),
    .leaf_score    (leaf_score),
    .feature_index (feature_index),
    .feature_value (feature_value),
    .cmd_valid     (fq_valid),
    .cmd_ready     (fq_ready),
    .cmd           (fq_cmd)
  );

  // decouple front from back
  dtree_queue u_queue (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (fq_valid),
    .in_ready  (fq_ready),
    .in_cmd    (fq_cmd),
    .out_valid (qb_valid),
    .out_ready (qb_ready),
    .out_cmd   (qb_cmd)
  );

  // execute writes and tree walks
  dtree_back #(
    .NODES    (NODES),
    .FEATURES (FEATURES)
  ) u_back (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_wdata (cfg_wdata),
    .cmd_valid (qb_valid),
    .cmd_ready (qb_ready),
    .cmd       (qb_cmd),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .score     (score),
    .status    (status)
  );

endmodule

// ===== rtl/dtree_front.sv =====
// front end: accepts input items, classifies them and drops those with no effect
module dtree_front #(
  parameter int NODES    = 256,
  parameter int FEATURES = 64
) (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  in_valid,
  output logic                  in_ready,
  input  logic [1:0]            func,
  input  logic [7:0]            node_index,
  input  logic                  leaf,
  input  logic [5:0]            node_dim,
  input  logic signed [31:0]    cut,
  input  logic [7:0]            child_below,
  input  logic [7:0]            child_above,
  input  logic signed [31:0]    leaf_score,
  input  logic [5:0]            feature_index,
  input  logic signed [31:0]    feature_value,
  output logic                  cmd_valid,
  input  logic                  cmd_ready,
  output dtree_pkg::cmd_t       cmd
);
  import dtree_pkg::*;

  localparam logic [31:0] NODES_W    = 32'(NODES);
  localparam logic [31:0] FEATURES_W = 32'(FEATURES);

  cmd_t cmd_class;
  logic keep;

  // decode the function and range-check write indexes
  always_comb begin
    cmd_class.op          = OP_EVAL;
    cmd_class.index       = node_index;
    cmd_class.leaf        = leaf;
    cmd_class.dim         = node_dim;
    cmd_class.cut         = cut;
    cmd_class.child_below = child_below;
    cmd_class.child_above = child_above;
    cmd_class.value       = leaf_score;
    keep                  = 1'b0;
    case (func)
      FUNC_NODE: begin
        cmd_class.op = OP_NODE;
        keep         = (32'(node_index) < NODES_W);
      end
      FUNC_FEAT: begin
        cmd_class.op    = OP_FEAT;
        cmd_class.index = 8'(feature_index);
        cmd_class.value = feature_value;
        keep            = (32'(feature_index) < FEATURES_W);
      end
      FUNC_EVAL: begin
        cmd_class.op = OP_EVAL;
        keep         = 1'b1;
      end
      default: keep = 1'b0;
    endcase
  end

  assign in_ready = !cmd_valid || cmd_ready;

  // classified item register
  always_ff @(posedge clk) begin
    if (rst) begin
      cmd_valid <= 1'b0;
    end else begin
      if (in_valid && in_ready) begin
        cmd_valid <= keep;
      end else if (cmd_ready) begin
        cmd_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      cmd <= cmd_class;
    end
  end

endmodule

// ===== rtl/dtree_queue.sv =====
// short command queue between front and back end
module dtree_queue (
  input  logic            clk,
  input  logic            rst,
  input  logic            in_valid,
  output logic            in_ready,
  input  dtree_pkg::cmd_t in_cmd,
  output logic            out_valid,
  input  logic            out_ready,
  output dtree_pkg::cmd_t out_cmd
);
  import dtree_pkg::*;

  cmd_t           slots [QDEPTH];
  logic [QAW-1:0] wr_ptr;
  logic [QAW-1:0] rd_ptr;
  logic [QAW:0]   count;
  logic           push;
  logic           pop;

  assign in_ready  = (count != (QAW+1)'(QDEPTH));
  assign out_valid = (count != '0);
  assign out_cmd   = slots[rd_ptr];
  assign push      = in_valid && in_ready;
  assign pop       = out_valid && out_ready;

  // pointers and fill count
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= wr_ptr + 1'b1;
      end
      if (pop) begin
        rd_ptr <= rd_ptr + 1'b1;
      end
      if (push && !pop) begin
        count <= count + 1'b1;
      end else if (pop && !push) begin
        count <= count - 1'b1;
      end
    end
  end

  // storage
  always_ff @(posedge clk) begin
    if (push) begin
      slots[wr_ptr] <= in_cmd;
    end
  end

  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    count <= (QAW+1)'(QDEPTH))
    else $error("queue fill count beyond depth");

endmodule

// ===== rtl/dtree_back.sv =====
// back end: node and feature memories, tree walk sequencer and result register
module dtree_back #(
  parameter int NODES    = 256,
  parameter int FEATURES = 64
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               cfg_we,
  input  logic [6:0]         cfg_wdata,
  input  logic               cmd_valid,
  output logic               cmd_ready,
  input  dtree_pkg::cmd_t    cmd,
  output logic               out_valid,
  input  logic               out_ready,
  output logic signed [31:0] score,
  output logic [1:0]         status
);
  import dtree_pkg::*;

  localparam int NAW = $clog2(NODES);
  localparam int NIW = (NAW > 8) ? NAW : 8;
  localparam int FAW = (FEATURES > 1) ? $clog2(FEATURES) : 1;
  localparam int FIW = (FAW > 8) ? FAW : 8;
  localparam int SW  = $clog2(NODES + 1);
  localparam logic [31:0] NODES_W    = 32'(NODES);
  localparam logic [31:0] FEATURES_W = 32'(FEATURES);

  node_t              node_mem [NODES];
  logic signed [31:0] feat_mem [FEATURES];

  bstate_t            state;
  bstate_t            state_next;
  logic [6:0]         feature_count;
  logic [SW-1:0]      steps;
  logic [SW-1:0]      steps_next;
  logic signed [31:0] res_score;
  logic signed [31:0] res_score_next;
  status_t            res_status;
  status_t            res_status_next;
  node_t              node_q;
  logic signed [31:0] feat_q;

  logic               node_we;
  logic               node_re;
  logic [NAW-1:0]     node_raddr;
  logic               feat_we;
  logic               feat_re;
  logic [FAW-1:0]     feat_raddr;
  logic               out_load;

  logic [NIW-1:0]     cmd_nidx;
  logic [FIW-1:0]     cmd_fidx;
  logic [FIW-1:0]     dim_ext;
  logic [7:0]         next_child;
  logic [NIW-1:0]     child_ext;
  logic               dim_bad;

  assign cmd_nidx   = NIW'(cmd.index);
  assign cmd_fidx   = FIW'(cmd.index);
  assign dim_ext    = FIW'(node_q.dim);
  assign next_child = (feat_q < node_q.cut) ? node_q.child_below : node_q.child_above;
  assign child_ext  = NIW'(next_child);
  assign dim_bad    = ({1'b0, node_q.dim} >= feature_count) || (32'(node_q.dim) >= FEATURES_W);
  assign cmd_ready  = (state == B_IDLE);

  // sequencer next state and memory controls
  always_comb begin
    state_next      = state;
    steps_next      = steps;
    res_score_next  = res_score;
    res_status_next = res_status;
    node_we         = 1'b0;
    node_re         = 1'b0;
    node_raddr      = '0;
    feat_we         = 1'b0;
    feat_re         = 1'b0;
    feat_raddr      = dim_ext[FAW-1:0];
    out_load        = 1'b0;
    case (state)
      B_IDLE: begin
        if (cmd_valid) begin
          case (cmd.op)
            OP_NODE: node_we = 1'b1;
            OP_FEAT: feat_we = 1'b1;
            OP_EVAL: begin
              node_re    = 1'b1;
              steps_next = '0;
              state_next = B_NODE;
            end
            default: ;
          endcase
        end
      end
      B_NODE: begin
        if (node_q.leaf) begin
          res_score_next  = node_q.value;
          res_status_next = ST_OK;
          state_next      = B_DONE;
        end else if (dim_bad) begin
          res_score_next  = '0;
          res_status_next = ST_DIM;
          state_next      = B_DONE;
        end else begin
          feat_re    = 1'b1;
          state_next = B_FEAT;
        end
      end
      B_FEAT: begin
        steps_next = steps + 1'b1;
        if ((steps_next == SW'(NODES)) || (32'(next_child) >= NODES_W)) begin
          res_score_next  = '0;
          res_status_next = ST_WALK;
          state_next      = B_DONE;
        end else begin
          node_re    = 1'b1;
          node_raddr = child_ext[NAW-1:0];
          state_next = B_NODE;
        end
      end
      B_DONE: begin
        if (!out_valid || out_ready) begin
          out_load   = 1'b1;
          state_next = B_IDLE;
        end
      end
      default: state_next = B_IDLE;
    endcase
  end

  // control registers
  always_ff @(posedge clk) begin
    if (rst) begin
      state         <= B_IDLE;
      feature_count <= FCOUNT_RESET;
      out_valid     <= 1'b0;
    end else begin
      state <= state_next;
      if (cfg_we) begin
        feature_count <= cfg_wdata;
      end
      if (out_load) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  // walk payload and result registers
  always_ff @(posedge clk) begin
    steps      <= steps_next;
    res_score  <= res_score_next;
    res_status <= res_status_next;
    if (out_load) begin
      score  <= res_score;
      status <= res_status;
    end
  end

  // node table
  always_ff @(posedge clk) begin
    if (node_we) begin
      node_mem[cmd_nidx[NAW-1:0]] <= '{leaf: cmd.leaf, dim: cmd.dim, cut: cmd.cut,
                                       child_below: cmd.child_below,
                                       child_above: cmd.child_above,
                                       value: cmd.value};
    end
    if (node_re) begin
      node_q <= node_mem[node_raddr];
    end
  end

  // feature store
  always_ff @(posedge clk) begin
    if (feat_we) begin
      feat_mem[cmd_fidx[FAW-1:0]] <= cmd.value;
    end
    if (feat_re) begin
      feat_q <= feat_mem[feat_raddr];
    end
  end

  a_feat_after_node: assert property (@(posedge clk) disable iff (rst)
    state == B_FEAT |-> $past(state) == B_NODE)
    else $error("feature compare without a node read before it");

  a_error_zero: assert property (@(posedge clk) disable iff (rst)
    (state == B_DONE && res_status != ST_OK) |-> res_score == '0)
    else $error("error result carries a nonzero score");

  a_steps_bound: assert property (@(posedge clk) disable iff (rst)
    state == B_NODE |-> steps < SW'(NODES))
    else $error("walk step count beyond node count");

endmodule
